// ===== rtl/core/dcds_pkg.sv =====
package dcds_pkg;

	localparam int YEAR_BITS_DEF  = 16;
	localparam int DAY_BITS       = 6;
	localparam int MONTH_BITS     = 4;
	localparam int WEEK_BITS      = 3;
	localparam int COUNT_BITS     = 25;
	localparam int OUT_YEAR_BITS  = 16;
	localparam int TDAY_BITS      = 5;
	localparam int CENT_BITS      = 7;

	localparam logic signed [DAY_BITS-1:0] JUL_DAY_INIT  = 6'sd1;
	localparam logic signed [DAY_BITS-1:0] GREG_DAY_INIT = -6'sd1;

	localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_BITS-1:0] MONTH_APR = 4'd4;
	localparam logic [MONTH_BITS-1:0] MONTH_JUN = 4'd6;
	localparam logic [MONTH_BITS-1:0] MONTH_SEP = 4'd9;
	localparam logic [MONTH_BITS-1:0] MONTH_NOV = 4'd11;
	localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;

	localparam logic [WEEK_BITS-1:0] WEEK_INIT = 3'd6;
	localparam logic [WEEK_BITS-1:0] WEEK_LAST = 3'd6;

	localparam logic [COUNT_BITS-1:0] COUNT_INIT = 25'd1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

	localparam int ADDR_BITS = 4;
	localparam logic [1:0] REG_TARGET_DAY   = 2'd0;
	localparam logic [1:0] REG_TARGET_MONTH = 2'd1;
	localparam logic [1:0] REG_TARGET_YEAR  = 2'd2;

	function automatic logic thirty_day_month(input logic [MONTH_BITS-1:0] m);
		return (m == MONTH_APR) || (m == MONTH_JUN) || (m == MONTH_SEP) ||
			(m == MONTH_NOV);
	endfunction

endpackage

// ===== rtl/core/dcds_calendar.sv =====
module dcds_calendar #(
	parameter int YEAR_BITS = dcds_pkg::YEAR_BITS_DEF,
	parameter bit GREGORIAN = 1'b0,
	parameter logic signed [dcds_pkg::DAY_BITS-1:0] DAY_INIT = dcds_pkg::JUL_DAY_INIT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  restart,
	input  logic                                  advance,
	output logic signed [dcds_pkg::DAY_BITS-1:0]  cur_day,
	output logic [dcds_pkg::MONTH_BITS-1:0]       cur_month,
	output logic [YEAR_BITS-1:0]                  cur_year
);
	import dcds_pkg::*;

	localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};
	localparam logic [CENT_BITS-1:0] CENT_LAST = 7'd99;

	logic signed [DAY_BITS-1:0] day_q, nxt_day;
	logic [MONTH_BITS-1:0]      month_q, nxt_month;
	logic [YEAR_BITS-1:0]       year_q, nxt_year;
	logic [CENT_BITS-1:0]       ymod100_q, cur_ymod100, nxt_ymod100;
	logic [1:0]                 cent4_q, cur_cent4, nxt_cent4;
	logic                       leap, month_end, year_inc;
	logic signed [DAY_BITS-1:0] feb_len;

	// restart shows the epoch in the same beat
	always_comb begin
		if (restart) begin
			cur_day     = DAY_INIT;
			cur_month   = MONTH_JAN;
			cur_year    = '0;
			cur_ymod100 = '0;
			cur_cent4   = '0;
		end else begin
			cur_day     = day_q;
			cur_month   = month_q;
			cur_year    = year_q;
			cur_ymod100 = ymod100_q;
			cur_cent4   = cent4_q;
		end
	end

	always_comb begin
		if (GREGORIAN)
			leap = (cur_year[1:0] == 2'd0) && ((cur_ymod100 != '0) || (cur_cent4 == 2'd0));
		else
			leap = (cur_year[1:0] == 2'd0);
		feb_len   = leap ? 6'sd29 : 6'sd28;
		month_end = (cur_day == 6'sd31) ||
			((cur_day == 6'sd30) && thirty_day_month(cur_month)) ||
			((cur_day == feb_len) && (cur_month == MONTH_FEB));
		year_inc  = (cur_day == 6'sd31) && (cur_month == MONTH_DEC) && (cur_year != YEAR_MAX);

		nxt_year    = cur_year;
		nxt_ymod100 = cur_ymod100;
		nxt_cent4   = cur_cent4;
		if (year_inc) begin
			nxt_year = cur_year + 1'b1;
			if (cur_ymod100 == CENT_LAST) begin
				nxt_ymod100 = '0;
				nxt_cent4   = cur_cent4 + 2'd1;
			end else begin
				nxt_ymod100 = cur_ymod100 + 1'b1;
			end
		end

		if (month_end) begin
			nxt_day   = 6'sd1;
			nxt_month = (cur_month == MONTH_DEC) ? MONTH_JAN : cur_month + 1'b1;
		end else begin
			nxt_day   = cur_day + 6'sd1;
			nxt_month = cur_month;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q     <= DAY_INIT;
			month_q   <= MONTH_JAN;
			year_q    <= '0;
			ymod100_q <= '0;
			cent4_q   <= '0;
		end else if (advance || restart) begin
			day_q     <= advance ? nxt_day     : cur_day;
			month_q   <= advance ? nxt_month   : cur_month;
			year_q    <= advance ? nxt_year    : cur_year;
			ymod100_q <= advance ? nxt_ymod100 : cur_ymod100;
			cent4_q   <= advance ? nxt_cent4   : cur_cent4;
		end
	end

endmodule

// ===== rtl/core/dual_calendar_day_stepper_unit.sv =====
// Dual calendar day stepper. Every tick beat reports the current Julian and
// Gregorian dates, weekday, running day number, a target-date match and a
// past-target flag, then steps both calendars one day; restart returns to the
// epoch in the same beat. One beat per cycle while tick_stall is low; the day
// step and leap tests are shallow logic from the state to the report register,
// and century leap rules come from small year-mod-100 and century counters.
// tick_stall is high only while a report is held and report_stall is high.
// Targets are set through the APB port at 0x0 (day), 0x4 (month), 0x8 (year);
// write them only while idle. Once past_target is set the state holds.
module dual_calendar_day_stepper_unit #(
	parameter int YEAR_BITS = dcds_pkg::YEAR_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   tick_valid,
	output logic                                   tick_stall,
	input  logic                                   restart,
	output logic                                   report_valid,
	input  logic                                   report_stall,
	output logic [dcds_pkg::TDAY_BITS-1:0]         julian_day,
	output logic [dcds_pkg::MONTH_BITS-1:0]        julian_month,
	output logic [dcds_pkg::OUT_YEAR_BITS-1:0]     julian_year,
	output logic signed [dcds_pkg::DAY_BITS-1:0]   gregorian_day,
	output logic [dcds_pkg::MONTH_BITS-1:0]        gregorian_month,
	output logic [dcds_pkg::OUT_YEAR_BITS-1:0]     gregorian_year,
	output logic [dcds_pkg::WEEK_BITS-1:0]         weekday,
	output logic [dcds_pkg::COUNT_BITS-1:0]        day_number,
	output logic                                   date_match,
	output logic                                   past_target,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [dcds_pkg::ADDR_BITS-1:0]         paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready
);
	import dcds_pkg::*;

	localparam int CMP_W = (YEAR_BITS > OUT_YEAR_BITS) ? YEAR_BITS : OUT_YEAR_BITS;

	logic [TDAY_BITS-1:0]     tgt_day_q;
	logic [MONTH_BITS-1:0]    tgt_month_q;
	logic [OUT_YEAR_BITS-1:0] tgt_year_q;

	logic accept, rst_beat, advance, past, jmatch, gmatch;
	logic cfg_wr;

	logic signed [DAY_BITS-1:0] j_day, g_day;
	logic [MONTH_BITS-1:0]      j_month, g_month;
	logic [YEAR_BITS-1:0]       j_year, g_year;
	logic [WEEK_BITS-1:0]       week_q, cur_week;
	logic [COUNT_BITS-1:0]      count_q, cur_count;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_day_q   <= TDAY_BITS'(1);
			tgt_month_q <= MONTH_JAN;
			tgt_year_q  <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_TARGET_DAY:   tgt_day_q   <= pwdata[TDAY_BITS-1:0];
				REG_TARGET_MONTH: tgt_month_q <= pwdata[MONTH_BITS-1:0];
				REG_TARGET_YEAR:  tgt_year_q  <= pwdata[OUT_YEAR_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_TARGET_DAY:   prdata = 32'(tgt_day_q);
			REG_TARGET_MONTH: prdata = 32'(tgt_month_q);
			REG_TARGET_YEAR:  prdata = 32'(tgt_year_q);
			default:          prdata = '0;
		endcase
	end

	assign tick_stall = report_valid && report_stall;
	assign accept     = tick_valid && !tick_stall;
	assign rst_beat   = accept && restart;
	assign advance    = accept && !past;

	dcds_calendar #(
		.YEAR_BITS (YEAR_BITS),
		.GREGORIAN (1'b0),
		.DAY_INIT  (JUL_DAY_INIT)
	) u_julian (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (rst_beat),
		.advance   (advance),
		.cur_day   (j_day),
		.cur_month (j_month),
		.cur_year  (j_year)
	);

	dcds_calendar #(
		.YEAR_BITS (YEAR_BITS),
		.GREGORIAN (1'b1),
		.DAY_INIT  (GREG_DAY_INIT)
	) u_gregorian (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (rst_beat),
		.advance   (advance),
		.cur_day   (g_day),
		.cur_month (g_month),
		.cur_year  (g_year)
	);

	assign cur_week  = rst_beat ? WEEK_INIT  : week_q;
	assign cur_count = rst_beat ? COUNT_INIT : count_q;

	always_comb begin
		jmatch = (j_day == $signed({1'b0, tgt_day_q})) && (j_month == tgt_month_q) &&
			(CMP_W'(j_year) == CMP_W'(tgt_year_q));
		gmatch = (g_day == $signed({1'b0, tgt_day_q})) && (g_month == tgt_month_q) &&
			(CMP_W'(g_year) == CMP_W'(tgt_year_q));
		past   = (CMP_W'(j_year) > CMP_W'(tgt_year_q)) &&
			(CMP_W'(g_year) > CMP_W'(tgt_year_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			week_q  <= WEEK_INIT;
			count_q <= COUNT_INIT;
		end else if (advance) begin
			week_q  <= (cur_week >= WEEK_LAST) ? '0 : cur_week + 1'b1;
			count_q <= (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
		end else if (rst_beat) begin
			week_q  <= cur_week;
			count_q <= cur_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			report_valid <= 1'b0;
		else if (accept)
			report_valid <= 1'b1;
		else if (!report_stall)
			report_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			julian_day      <= j_day[TDAY_BITS-1:0];
			julian_month    <= j_month;
			julian_year     <= OUT_YEAR_BITS'(j_year);
			gregorian_day   <= g_day;
			gregorian_month <= g_month;
			gregorian_year  <= OUT_YEAR_BITS'(g_year);
			weekday         <= cur_week;
			day_number      <= cur_count;
			date_match      <= jmatch || gmatch;
			past_target     <= past;
		end
	end

endmodule

// ===== rtl/core/dcds_checker.sv =====
module dcds_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  tick_valid,
	input logic                                  tick_stall,
	input logic                                  restart,
	input logic                                  report_valid,
	input logic                                  report_stall,
	input logic [dcds_pkg::TDAY_BITS-1:0]        julian_day,
	input logic signed [dcds_pkg::DAY_BITS-1:0]  gregorian_day,
	input logic [dcds_pkg::WEEK_BITS-1:0]        weekday,
	input logic [dcds_pkg::COUNT_BITS-1:0]       day_number
);
	import dcds_pkg::*;

	// held report stays up
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && report_stall |=> report_valid)
		else $error("report dropped while stalled");

	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!report_valid |-> !tick_stall)
		else $error("tick stalled with empty report register");

	a_beat_out: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && !tick_stall |=> report_valid)
		else $error("accepted tick produced no report");

	a_restart_epoch: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && !tick_stall && restart |=>
		(day_number == COUNT_INIT) && (julian_day == TDAY_BITS'(1)) &&
		(gregorian_day == GREG_DAY_INIT) && (weekday == WEEK_INIT))
		else $error("restart did not report the epoch");

	a_weekday: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid |-> weekday <= WEEK_LAST)
		else $error("weekday out of range");

endmodule

bind dual_calendar_day_stepper_unit dcds_checker u_dcds_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.tick_valid    (tick_valid),
	.tick_stall    (tick_stall),
	.restart       (restart),
	.report_valid  (report_valid),
	.report_stall  (report_stall),
	.julian_day    (julian_day),
	.gregorian_day (gregorian_day),
	.weekday       (weekday),
	.day_number    (day_number)
);

// ===== bench/dual_calendar_day_stepper_checker.sv =====
`timescale 1ns / 1ps

module dual_calendar_day_stepper_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  tick_valid,
	input  logic                                  tick_stall,
	input  logic                                  restart,
	input  logic                                  report_valid,
	input  logic                                  report_stall,
	input  logic [dcds_pkg::TDAY_BITS-1:0]        julian_day,
	input  logic [dcds_pkg::MONTH_BITS-1:0]       julian_month,
	input  logic [dcds_pkg::OUT_YEAR_BITS-1:0]    julian_year,
	input  logic signed [dcds_pkg::DAY_BITS-1:0]  gregorian_day,
	input  logic [dcds_pkg::MONTH_BITS-1:0]       gregorian_month,
	input  logic [dcds_pkg::OUT_YEAR_BITS-1:0]    gregorian_year,
	input  logic [dcds_pkg::WEEK_BITS-1:0]        weekday,
	input  logic [dcds_pkg::COUNT_BITS-1:0]       day_number,
	input  logic                                  date_match,
	input  logic                                  past_target,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic                                  pready,
	input  logic [dcds_pkg::ADDR_BITS-1:0]        paddr,
	input  logic [31:0]                           pwdata,
	output int                                    mismatches,
	output int                                    pending,
	output int                                    checked,
	output int                                    hits,
	output int                                    pasts
);
	import dcds_pkg::*;

	typedef struct packed {
		logic [TDAY_BITS-1:0]       jday;
		logic [MONTH_BITS-1:0]      jmon;
		logic [OUT_YEAR_BITS-1:0]   jyear;
		logic signed [DAY_BITS-1:0] gday;
		logic [MONTH_BITS-1:0]      gmon;
		logic [OUT_YEAR_BITS-1:0]   gyear;
		logic [WEEK_BITS-1:0]       wday;
		logic [COUNT_BITS-1:0]      dnum;
		logic                       hit;
		logic                       past;
	} report_t;

	localparam int YEAR_TOP = (1 << YEAR_BITS_DEF) - 1;

	logic [TDAY_BITS-1:0]     want_day;
	logic [MONTH_BITS-1:0]    want_month;
	logic [OUT_YEAR_BITS-1:0] want_year;

	int jd, jm, jy, gd, gm, gy, wk, dc;
	report_t due_reports[$];

	function automatic int greg_feb_len(input int y);
		return ((y % 400 == 0) || (y % 4 == 0 && y % 100 != 0)) ? 29 : 28;
	endfunction

	task automatic roll_date(inout int d, inout int m, inout int y, input int feb_len);
		bit short_month;
		short_month = (m == MONTH_APR) || (m == MONTH_JUN) || (m == MONTH_SEP) ||
			(m == MONTH_NOV);
		if (d == 31 && m == MONTH_DEC && y < YEAR_TOP)
			y++;
		if (d == 31 || (d == 30 && short_month) || (d == feb_len && m == MONTH_FEB)) begin
			m = (m % 12) + 1;
			d = 1;
		end else begin
			d++;
		end
	endtask

	task automatic to_epoch();
		jd = JUL_DAY_INIT;
		jm = MONTH_JAN;
		jy = 0;
		gd = GREG_DAY_INIT;
		gm = MONTH_JAN;
		gy = 0;
		wk = WEEK_INIT;
		dc = COUNT_INIT;
	endtask

	task automatic step_calendars(input bit rs, output report_t r);
		bit past;
		if (rs)
			to_epoch();
		past = (jy > int'(want_year)) && (gy > int'(want_year));
		r.jday  = jd[TDAY_BITS-1:0];
		r.jmon  = jm[MONTH_BITS-1:0];
		r.jyear = jy[OUT_YEAR_BITS-1:0];
		r.gday  = gd[DAY_BITS-1:0];
		r.gmon  = gm[MONTH_BITS-1:0];
		r.gyear = gy[OUT_YEAR_BITS-1:0];
		r.wday  = wk[WEEK_BITS-1:0];
		r.dnum  = dc[COUNT_BITS-1:0];
		r.hit   = (jd == int'(want_day) && jm == int'(want_month) && jy == int'(want_year)) ||
			(gd == int'(want_day) && gm == int'(want_month) && gy == int'(want_year));
		r.past  = past;
		if (!past) begin
			wk = (wk >= WEEK_LAST) ? 0 : wk + 1;
			if (dc < int'(COUNT_MAX))
				dc++;
			roll_date(jd, jm, jy, (jy % 4 == 0) ? 29 : 28);
			roll_date(gd, gm, gy, greg_feb_len(gy));
		end
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("report beat %0d: %s expected %0d, got %0d", checked, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		report_t want, got;
		if (!arst_n) begin
			want_day = TDAY_BITS'(1);
			want_month = MONTH_JAN;
			want_year = '0;
			to_epoch();
			due_reports.delete();
			mismatches = 0;
			pending = 0;
			checked = 0;
			hits = 0;
			pasts = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_BITS-1:2])
					REG_TARGET_DAY:   want_day = pwdata[TDAY_BITS-1:0];
					REG_TARGET_MONTH: want_month = pwdata[MONTH_BITS-1:0];
					REG_TARGET_YEAR:  want_year = pwdata[OUT_YEAR_BITS-1:0];
					default: ;
				endcase
			end
			if (report_valid && !report_stall) begin
				got = {julian_day, julian_month, julian_year, gregorian_day, gregorian_month,
					gregorian_year, weekday, day_number, date_match, past_target};
				if (due_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("report beat %0d arrived with no tick outstanding", checked);
				end else begin
					want = due_reports.pop_front();
					check_field("julian_day", want.jday, got.jday);
					check_field("julian_month", want.jmon, got.jmon);
					check_field("julian_year", want.jyear, got.jyear);
					check_field("gregorian_day", want.gday, got.gday);
					check_field("gregorian_month", want.gmon, got.gmon);
					check_field("gregorian_year", want.gyear, got.gyear);
					check_field("weekday", want.wday, got.wday);
					check_field("day_number", want.dnum, got.dnum);
					check_field("date_match", want.hit, got.hit);
					check_field("past_target", want.past, got.past);
				end
				checked++;
				if (got.hit)
					hits++;
				if (got.past)
					pasts++;
			end
			if (tick_valid && !tick_stall) begin
				step_calendars(restart, want);
				due_reports.push_back(want);
			end
			pending = due_reports.size();
		end
	end

endmodule

// ===== bench/dual_calendar_day_stepper_unit_tb.sv =====
`timescale 1ns / 1ps

module dual_calendar_day_stepper_unit_tb;
	import dcds_pkg::*;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       tick_valid;
	logic                       tick_stall;
	logic                       restart;
	logic                       report_valid;
	logic                       report_stall = 1'b0;
	logic [TDAY_BITS-1:0]       julian_day;
	logic [MONTH_BITS-1:0]      julian_month;
	logic [OUT_YEAR_BITS-1:0]   julian_year;
	logic signed [DAY_BITS-1:0] gregorian_day;
	logic [MONTH_BITS-1:0]      gregorian_month;
	logic [OUT_YEAR_BITS-1:0]   gregorian_year;
	logic [WEEK_BITS-1:0]       weekday;
	logic [COUNT_BITS-1:0]      day_number;
	logic                       date_match;
	logic                       past_target;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [ADDR_BITS-1:0]       paddr;
	logic [31:0]                pwdata;
	logic [31:0]                prdata;
	logic                       pready;

	int mismatches, pending, checked, hits, pasts;
	int send_idle, stall_pct, ticks_sent, restarts_sent;

	// per phase: target date, tick count, sender idle %, receiver stall %, restart odds
	int ph_day [4]   = '{29, 31, 0, 30};
	int ph_month [4] = '{2, 12, 15, 1};
	int ph_year [4]  = '{0, 1, 65535, 0};
	int ph_ticks [4] = '{400, 380, 150, 120};
	int ph_idle [4]  = '{0, 49, 0, 15};
	int ph_stall [4] = '{0, 0, 49, 15};
	int ph_odds [4]  = '{0, 0, 16, 64};

	bit opening_ticks [20] = '{0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0};

	dual_calendar_day_stepper_unit dut (.*);

	dual_calendar_day_stepper_checker chk (.*);

	always #5 clk = ~clk;

	always @(negedge clk)
		report_stall <= ($urandom_range(99) < stall_pct);

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_tick(input bit rs);
		while ($urandom_range(99) < send_idle) begin
			tick_valid <= 1'b0;
			@(negedge clk);
		end
		tick_valid <= 1'b1;
		restart <= rs;
		@(posedge clk);
		while (tick_stall)
			@(posedge clk);
		ticks_sent++;
		if (rs)
			restarts_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		@(negedge clk);
		while (pending != 0 && guard < 2000) begin
			guard++;
			@(negedge clk);
		end
	endtask

	initial begin
		bit rs;
		arst_n = 1'b0;
		tick_valid = 1'b0;
		restart = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle = 0;
		stall_pct = 0;
		ticks_sent = 0;
		restarts_sent = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// day zero target: only the Gregorian offset day can hit it
		write_reg(REG_TARGET_DAY, 0);
		foreach (opening_ticks[i])
			send_tick(opening_ticks[i]);
		tick_valid <= 1'b0;
		drain();

		for (int p = 0; p < 4; p++) begin
			write_reg(REG_TARGET_DAY, ph_day[p]);
			write_reg(REG_TARGET_MONTH, ph_month[p]);
			write_reg(REG_TARGET_YEAR, ph_year[p]);
			send_idle = ph_idle[p];
			stall_pct = ph_stall[p];
			for (int i = 0; i < ph_ticks[p]; i++) begin
				// second phase carries on from the frozen state of the first
				rs = (i == 0 && p != 1) ||
					(ph_odds[p] != 0 && $urandom_range(ph_odds[p] - 1) == 0);
				if (p == 1 && i == ph_ticks[p] / 2) begin
					tick_valid <= 1'b0;
					drain();
				end
				send_tick(rs);
			end
			tick_valid <= 1'b0;
			drain();
		end

		stall_pct = 0;
		drain();
		repeat (5) @(negedge clk);

		$display("sent %0d day ticks (%0d restarts) across five target settings and four pacing modes",
			ticks_sent, restarts_sent);
		$display("checked %0d report beats: %0d target hits, %0d past-target reports",
			checked, hits, pasts);
		if (mismatches == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/dcds_pkg.sv
rtl/core/dcds_calendar.sv
rtl/core/dual_calendar_day_stepper_unit.sv
rtl/core/dcds_checker.sv
bench/dual_calendar_day_stepper_checker.sv
bench/dual_calendar_day_stepper_unit_tb.sv
